/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define RGBYUV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset
`define RGBYUV_NEVER(lbl, cond, msg) \
	`RGBYUV_ASSERT(lbl, !(cond), msg)

`endif

/* hw/rtl/rgbyuv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Types, constants and helpers shared by the RGB to 4:2:0 YCbCr converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbyuv_pkg;

	// Frame size limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// Size register field width, fixed by the register map
	localparam int SIZE_W = 12;

	// Counter widths: enough for the largest last index
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CNT_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((CNT_MAX_W > SIZE_W) ? CNT_MAX_W : SIZE_W) + 1;

	// Half-width line buffer of pair sums
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W     = $clog2(LINE_DEPTH);
	localparam int PAIR_W     = 9;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// One classified pixel, front to back
	typedef struct packed {
		logic [7:0]        luma;
		logic [7:0]        cb;
		logic [7:0]        cr;
		logic              col_odd;
		logic              row_odd;
		logic [SLOT_W-1:0] slot;
		logic              frame_end;
	} pix_item_t;

	// Clamp a size register to 2..max and round down to even
	function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input logic [CMP_W-1:0] max_v);
		logic [CMP_W-1:0] s;
		s = CMP_W'(v);
		if (s < CMP_W'(2)) s = CMP_W'(2);
		if (s > max_v) s = max_v;
		s[0] = 1'b0;
		return s;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgbyuv_front.sv */
// ----------------------------------------------------------------------------
// rgbyuv_front
// Accepts pixels, holds the size registers and raster counters, computes
// per-pixel Y, Cb and Cr terms and tags each item with its 2x2 position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_front import rgbyuv_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pixel input
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [31:0]          pixel_argb,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	// queue push side
	input  wire logic                 q_full,
	output logic                      q_push,
	output pix_item_t                 q_item
);

	logic [SIZE_W-1:0] width_q, height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [CMP_W-1:0]  eff_w, eff_h;
	logic              col_wrap, row_wrap;

	logic [7:0]  r, g, b;
	logic [15:0] y_sum, cb_sum, cr_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign q_push    = in_valid && in_ready;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = eff_size(width_q, CMP_W'(MAX_WIDTH));
	assign eff_h = eff_size(height_q, CMP_W'(MAX_HEIGHT));

	// Wrap when the next index reaches the size; also catches counters past it
	assign col_wrap = (CMP_W'(col_q) + CMP_W'(1)) >= eff_w;
	assign row_wrap = (CMP_W'(row_q) + CMP_W'(1)) >= eff_h;

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Color terms; offsets fold in the rounding and the +128 chroma bias,
	// and the true values stay in 0..65535 so 16-bit wraparound is exact
	assign r = pixel_argb[23:16];
	assign g = pixel_argb[15:8];
	assign b = pixel_argb[7:0];

	assign y_sum  = 16'd128 + 16'(r) * 16'd66 + 16'(g) * 16'd129 + 16'(b) * 16'd25;
	assign cb_sum = 16'd32896 + 16'(b) * 16'd112 - 16'(r) * 16'd38 - 16'(g) * 16'd74;
	assign cr_sum = 16'd32896 + 16'(r) * 16'd112 - 16'(g) * 16'd94 - 16'(b) * 16'd18;

	always_comb begin
		q_item.luma      = y_sum[15:8] + 8'd16;
		q_item.cb        = cb_sum[15:8];
		q_item.cr        = cr_sum[15:8];
		q_item.col_odd   = col_q[0];
		q_item.row_odd   = row_q[0];
		q_item.slot      = col_q[COL_W-1:1];
		q_item.frame_end = col_wrap && row_wrap;
	end

endmodule

`default_nettype wire

/* hw/rtl/rgbyuv_queue.sv */
// ----------------------------------------------------------------------------
// rgbyuv_queue
// Short flop FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgbyuv_queue import rgbyuv_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pix_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           not_empty,
	output pix_item_t      head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_item_t          slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	`RGBYUV_NEVER(a_push_when_full, push && full, "queue push while full")
	`RGBYUV_NEVER(a_pop_when_empty, pop && !not_empty, "queue pop while empty")
	`RGBYUV_ASSERT(a_count_up, (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)), "queue count did not rise on push")
	`RGBYUV_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

/* hw/rtl/rgbyuv_back.sv */
// ----------------------------------------------------------------------------
// rgbyuv_back
// Forms horizontal pair sums, stores them on even rows in the half-width line
// buffer, and on odd rows adds the buffered sums to give 2x2 chroma averages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_back import rgbyuv_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	// queue pop side
	input  wire logic      q_not_empty,
	input  wire pix_item_t q_head,
	output logic           q_pop,
	// result output
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     luma,
	output logic           chroma_valid,
	output logic [7:0]     chroma_blue,
	output logic [7:0]     chroma_red,
	output logic           frame_end
);

	// Line buffer, undefined until written
	logic [2*PAIR_W-1:0] line_mem [LINE_DEPTH];

	logic [PAIR_W-1:0]   blue_pair_q, red_pair_q;
	logic [PAIR_W-1:0]   blue_pair_nx, red_pair_nx;

	logic                valid_s1;
	logic [7:0]          luma_s1;
	logic                chroma_s1;
	logic                fend_s1;
	logic [PAIR_W-1:0]   blue_sum_s1, red_sum_s1;
	logic [2*PAIR_W-1:0] line_rd_s1;

	logic                out_load, s1_free;
	logic [PAIR_W:0]     blue_tot, red_tot;

	// Pipeline advance
	assign out_load = valid_s1 && (!out_valid || out_ready);
	assign s1_free  = !valid_s1 || out_load;
	assign q_pop    = q_not_empty && s1_free;

	// Next pair sums: even column starts a pair, odd column closes it
	always_comb begin
		if (!q_head.col_odd) begin
			blue_pair_nx = PAIR_W'(q_head.cb);
			red_pair_nx  = PAIR_W'(q_head.cr);
		end else begin
			blue_pair_nx = blue_pair_q + PAIR_W'(q_head.cb);
			red_pair_nx  = red_pair_q + PAIR_W'(q_head.cr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_pair_q <= '0;
			red_pair_q  <= '0;
		end else if (q_pop) begin
			blue_pair_q <= blue_pair_nx;
			red_pair_q  <= red_pair_nx;
		end
	end

	// Line buffer: write on even rows, registered read on odd rows
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_head.col_odd && !q_head.row_odd)
				line_mem[q_head.slot] <= {blue_pair_nx, red_pair_nx};
			line_rd_s1 <= line_mem[q_head.slot];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_pop;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			luma_s1     <= q_head.luma;
			chroma_s1   <= q_head.col_odd && q_head.row_odd;
			fend_s1     <= q_head.frame_end;
			blue_sum_s1 <= blue_pair_nx;
			red_sum_s1  <= red_pair_nx;
		end
	end

	// 2x2 totals; average is the total over four
	assign blue_tot = (PAIR_W + 1)'(line_rd_s1[2*PAIR_W-1:PAIR_W]) + (PAIR_W + 1)'(blue_sum_s1);
	assign red_tot  = (PAIR_W + 1)'(line_rd_s1[PAIR_W-1:0]) + (PAIR_W + 1)'(red_sum_s1);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			luma         <= luma_s1;
			chroma_valid <= chroma_s1;
			chroma_blue  <= chroma_s1 ? blue_tot[PAIR_W:2] : 8'd0;
			chroma_red   <= chroma_s1 ? red_tot[PAIR_W:2] : 8'd0;
			frame_end    <= fend_s1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_yuv420_converter_core.sv */
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// ARGB raster pixels in, BT.601 limited-range Y per pixel and 4:2:0 Cb/Cr
// averages on the pixel that closes each 2x2 block.
//
//   channel  signals                              direction
//   in       in_valid/in_ready, pixel_argb         sink
//   out      out_valid/out_ready, luma, chroma_*,  source
//            frame_end
//   cfg      cfg_valid/cfg_ready, cfg_index,       sink, always ready
//            cfg_data
//
// One pixel per clock sustained while out_ready is high; out_valid rises after
// queue entry, the line buffer read stage and the output register.
// The line buffer takes one read and at most one write per item, one port each,
// which keeps the rate at one item per clock.
// A 4-entry queue between front and back absorbs output stalls; in_ready
// drops only when it is full. Reset clears counters, pair sums and control;
// the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_yuv420_converter_core import rgbyuv_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [31:0]          pixel_argb,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                luma,
	output logic                      chroma_valid,
	output logic [7:0]                chroma_blue,
	output logic [7:0]                chroma_red,
	output logic                      frame_end,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data
);

	logic      q_full, q_push, q_pop, q_not_empty;
	pix_item_t q_item, q_head;

	rgbyuv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_argb (pixel_argb),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	rgbyuv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	rgbyuv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.luma         (luma),
		.chroma_valid (chroma_valid),
		.chroma_blue  (chroma_blue),
		.chroma_red   (chroma_red),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire
